/* rtl/sris_pkg.sv */
// Shared types, field widths, sort-mode codes and the sort key function of the record sorter.
package sris_pkg;

	localparam int NUM_W   = 32;
	localparam int SCORE_W = 16;
	localparam int REC_W   = NUM_W + SCORE_W;
	localparam int KEY_W   = NUM_W + SCORE_W;
	localparam int MODE_W  = 2;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [REC_W-1:0]  rec_t;
	typedef logic [KEY_W-1:0]  key_t;

	// Sort-mode codes. The unused code sorts as number then score.
	localparam mode_t MODE_SCORE     = 2'd0;
	localparam mode_t MODE_NUMBER    = 2'd1;
	localparam mode_t MODE_NUM_SCORE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;       // take the incoming record into the store
		logic clear_best;  // start a new selection pass
		logic rd_en;       // read one stored record for comparison
		logic load_out;    // move the selected record into the output register
		logic last;        // the loaded record closes the listing
		logic finish;      // empty the store after the listing
	} sris_cmd_t;

	function automatic key_t key_of(mode_t mode, logic [NUM_W-1:0] num,
		logic [SCORE_W-1:0] sc);
		key_t k;
		case (mode)
			MODE_SCORE:  k = {{(KEY_W-SCORE_W){1'b0}}, sc};
			MODE_NUMBER: k = {{(KEY_W-NUM_W){1'b0}}, num};
			default:     k = {num, sc};
		endcase
		return k;
	endfunction

endpackage

/* rtl/stable_record_insertion_sort.sv */
// Top level of the stable record sorter: controller, datapath and their connection.
//
// Records of student number and score stream in on the slave side and are kept in arrival
// order in an on-chip store of MAX_RECORDS entries. A record with tlast set closes the set:
// it is stored like the others, and then the whole set is sent out on the master side in
// ascending order of the key picked by the sort-mode register (0: score, 1: student number,
// 2 or 3: student number with score as tiebreak). Records with equal keys leave in the order
// they arrived. Records that arrive while the store is full are dropped, and every record of
// that listing carries the overflow flag in m_tuser; a dropped record that carries tlast still
// starts the listing. While records are being collected, s_tready is held high.
// Every result is found by a selection pass that reads all stored records through the
// single read port of the store, then makes the last compare and loads the output register;
// that load waits while the sink stalls. No input is taken during a listing; the next set
// may start as soon as the final result sits in the output register. The sort mode is
// written through cfg_we and cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce.
module stable_record_insertion_sort #(
	parameter int MAX_RECORDS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration: sort mode.
	input  logic                 cfg_we,
	input  sris_pkg::mode_t      cfg_wdata,
	// Slave side.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sris_pkg::rec_t       s_tdata,   // [31:0] student_number, [47:32] score
	input  logic                 s_tlast,   // last_record
	// Master side.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output sris_pkg::rec_t       m_tdata,   // [31:0] out_number, [47:32] out_score
	output logic                 m_tlast,   // last_out
	output logic                 m_tuser    // overflow
);
	import sris_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	sris_cmd_t     cmd;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count;
	logic          out_free;

	// The controller sequences collection and the selection passes.
	sris_ctrl #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.count   (count),
		.out_free(out_free),
		.cmd     (cmd),
		.rd_addr (rd_addr)
	);

	// The datapath holds the records and picks the next one in key order on each pass.
	sris_datapath #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.count    (count),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/sris_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module sris_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sris_datapath.sv */
// Datapath of the record sorter: record store, fill count, selection compare and output register.
module sris_datapath #(
	parameter int MAX_RECORDS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  sris_pkg::mode_t                    cfg_wdata,
	input  sris_pkg::rec_t                     s_tdata,
	input  sris_pkg::sris_cmd_t                cmd,
	input  logic [$clog2(MAX_RECORDS)-1:0]     rd_addr,
	output logic [$clog2(MAX_RECORDS+1)-1:0]   count,
	output logic                               out_free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output sris_pkg::rec_t                     m_tdata,
	output logic                               m_tlast,
	output logic                               m_tuser
);
	import sris_pkg::*;

	localparam int AW    = $clog2(MAX_RECORDS);
	localparam int CW    = $clog2(MAX_RECORDS + 1);
	localparam int EXT_W = KEY_W + AW;

	mode_t            mode_q;
	logic [CW-1:0]    count_q;
	logic             dropped_q;
	logic             has_room;
	rec_t             rdata;
	logic             rd_valid_s1;
	logic [AW-1:0]    idx_s1;
	logic [EXT_W-1:0] cand_ext;
	logic             take;
	logic [EXT_W-1:0] best_ext_q;
	rec_t             best_rec_q;
	logic             best_valid_q;
	logic [EXT_W-1:0] prev_ext_q;
	logic             prev_valid_q;
	logic             m_tvalid_q;

	assign has_room = (count_q < CW'(MAX_RECORDS));
	assign count    = count_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	sris_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_RECORDS)
	) u_store (
		.clk  (clk),
		.we   (cmd.store && has_room),
		.waddr(count_q[AW-1:0]),
		.wdata(s_tdata),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// The arrival index makes every extended key unique, which keeps equal keys in order.
	assign cand_ext = {key_of(mode_q, rdata[NUM_W-1:0], rdata[REC_W-1:NUM_W]), idx_s1};
	assign take = rd_valid_s1 && (!prev_valid_q || (cand_ext > prev_ext_q)) &&
		(!best_valid_q || (cand_ext < best_ext_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SCORE;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			rd_valid_s1  <= 1'b0;
			best_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.finish) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.store) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.clear_best) begin
				best_valid_q <= 1'b0;
			end else if (take) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.finish) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.load_out) begin
				prev_valid_q <= 1'b1;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (take) begin
			best_ext_q <= cand_ext;
			best_rec_q <= rdata;
		end
		if (cmd.load_out) begin
			prev_ext_q <= best_ext_q;
			m_tdata    <= best_rec_q;
			m_tlast    <= cmd.last;
			m_tuser    <= dropped_q;
		end
	end

endmodule

/* rtl/sris_ctrl.sv */
// Controller of the record sorter: collects records, then runs one selection pass per result.
module sris_ctrl #(
	parameter int MAX_RECORDS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tlast,
	output logic                               s_tready,
	input  logic [$clog2(MAX_RECORDS+1)-1:0]   count,
	input  logic                               out_free,
	output sris_pkg::sris_cmd_t                cmd,
	output logic [$clog2(MAX_RECORDS)-1:0]     rd_addr
);
	import sris_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] rd_addr_q;
	logic [CW-1:0] emitted_q;
	logic          scan_end;
	logic          emit_last;

	assign scan_end  = (CW'(rd_addr_q) == (count - CW'(1)));
	assign emit_last = (emitted_q == (count - CW'(1)));
	assign rd_addr   = rd_addr_q;
	assign s_tready  = (state_q == ST_COLLECT);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_COLLECT: begin
				cmd.store      = s_tvalid;
				cmd.clear_best = s_tvalid && s_tlast;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			ST_WAIT: begin
				cmd = '0;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out   = 1'b1;
					cmd.last       = emit_last;
					cmd.finish     = emit_last;
					cmd.clear_best = !emit_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			rd_addr_q <= '0;
			emitted_q <= '0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (s_tvalid && s_tlast) begin
						state_q   <= ST_SCAN;
						rd_addr_q <= '0;
						emitted_q <= '0;
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (scan_end) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_COLLECT;
						end else begin
							state_q   <= ST_SCAN;
							rd_addr_q <= '0;
							emitted_q <= emitted_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

/* rtl/sris_checker.sv */
// Port-level assertions for the record sorter and the bind that attaches them.
module sris_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_we,
	input sris_pkg::mode_t cfg_wdata,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic            s_tlast,
	input logic            m_tvalid,
	input logic            m_tready,
	input sris_pkg::rec_t  m_tdata,
	input logic            m_tlast
);
	import sris_pkg::*;

	mode_t              mode_q;
	logic               in_list_q;
	logic [NUM_W-1:0]   prev_num_q;
	logic [SCORE_W-1:0] prev_score_q;
	logic               out_xfer;

	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SCORE;
			in_list_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (out_xfer) begin
				in_list_q <= !m_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			prev_num_q   <= m_tdata[NUM_W-1:0];
			prev_score_q <= m_tdata[REC_W-1:NUM_W];
		end
	end

	// A result that is not taken stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// The record that closes a set starts the listing, so no input follows at once.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after the closing record");

	// While a listing is under way no new record is taken.
	a_no_input_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during a listing");

	// Within a listing the selected key never decreases; checked in the score and number modes.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && in_list_q |->
		(mode_q != MODE_SCORE || m_tdata[REC_W-1:NUM_W] >= prev_score_q) &&
		(mode_q != MODE_NUMBER || m_tdata[NUM_W-1:0] >= prev_num_q))
		else $error("listing out of order");

endmodule

bind stable_record_insertion_sort sris_checker u_sris_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.cfg_wdata(cfg_wdata),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* test/stable_record_insertion_sort_tb.sv */
// Testbench for the stable record sorter: directed and random streams of records checked against a predictor.
`timescale 1ns / 100ps

module stable_record_insertion_sort_tb;

	import sris_pkg::*;

	localparam int    STORE_DEPTH  = 64;
	localparam int    RECORD_ITEMS = 410;
	localparam int    DRAIN_CYCLES = 16;
	localparam int    TAIL_CYCLES  = 200;
	localparam int    CYCLE_LIMIT  = 20000000;
	// The fourth mode code has no name in the package; it sorts as number then score.
	localparam mode_t MODE_UNUSED  = 2'd3;

	typedef struct {
		logic [NUM_W-1:0]   number;
		logic [SCORE_W-1:0] score;
		logic               last;
	} student_rec_t;

	typedef struct {
		logic [NUM_W-1:0]   number;
		logic [SCORE_W-1:0] score;
		logic               last;
		logic               overflow;
	} listing_rec_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_we    = 1'b0;
	mode_t cfg_wdata = MODE_SCORE;
	logic  s_tvalid  = 1'b0;
	logic  s_tready;
	rec_t  s_tdata   = '0;
	logic  s_tlast   = 1'b0;
	logic  m_tvalid;
	logic  m_tready  = 1'b0;
	rec_t  m_tdata;
	logic  m_tlast;
	logic  m_tuser;

	// Records waiting to be offered, and the sorted listing the block should give out.
	student_rec_t pending_recs[$];
	listing_rec_t sorted_listing_q[$];

	// Predictor state: records held in arrival order, drop flag and the sort mode.
	logic [NUM_W-1:0]   held_number[STORE_DEPTH];
	logic [SCORE_W-1:0] held_score[STORE_DEPTH];
	int                 held_count   = 0;
	bit                 held_dropped = 1'b0;
	mode_t              sort_mode    = MODE_SCORE;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int items_queued   = 0;
	int send_hold      = 0;
	int sink_hold      = 0;
	bit send_idle_en   = 1'b1;
	bit sink_idle_en   = 1'b1;
	bit s_took         = 1'b0;

	stable_record_insertion_sort #(
		.MAX_RECORDS(STORE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Key of a record under the given mode; the unused code sorts as number then score.
	function automatic logic [47:0] record_key(mode_t mode, logic [NUM_W-1:0] num,
		logic [SCORE_W-1:0] sc);
		if (mode == MODE_SCORE)
			return {32'd0, sc};
		else if (mode == MODE_NUMBER)
			return {16'd0, num};
		return {num, sc};
	endfunction

	// Mostly short gaps, a few long ones; none at all when idling is off for the phase.
	function automatic int pick_gap(bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [NUM_W-1:0] rand_number();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SCORE_W-1:0] rand_score();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SCORE_W'($urandom_range(0, 7));
			default: return SCORE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		$display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Store or drop one accepted record; a last record turns the held set into a listing.
	task automatic take_record(logic [NUM_W-1:0] num, logic [SCORE_W-1:0] sc, logic last);
		listing_rec_t order[$];
		listing_rec_t r;
		logic [47:0]  k;
		int           pos;
		if (held_count < STORE_DEPTH) begin
			held_number[held_count] = num;
			held_score[held_count]  = sc;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			// Stable insertion: each record goes before the first placed one with a greater key.
			for (int i = 0; i < held_count; i++) begin
				k   = record_key(sort_mode, held_number[i], held_score[i]);
				pos = 0;
				while (pos < order.size() &&
					record_key(sort_mode, order[pos].number, order[pos].score) <= k)
					pos++;
				r.number   = held_number[i];
				r.score    = held_score[i];
				r.last     = 1'b0;
				r.overflow = held_dropped;
				order.insert(pos, r);
			end
			order[order.size()-1].last = 1'b1;
			foreach (order[i])
				sorted_listing_q.push_back(order[i]);
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endtask

	// Monitor: samples both sides and the register write at the rising edge.
	always @(posedge clk) begin
		listing_rec_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			s_took <= s_tvalid && s_tready;
			if (arst_n && cfg_we)
				sort_mode = cfg_wdata;
			if (arst_n && s_tvalid && s_tready)
				take_record(s_tdata[31:0], s_tdata[47:32], s_tlast);
			if (arst_n && m_tvalid && m_tready) begin
				if (sorted_listing_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = sorted_listing_q.pop_front();
					if (m_tdata[31:0] !== want.number)
						report_mismatch("out_number", 48'(m_tdata[31:0]), 48'(want.number));
					if (m_tdata[47:32] !== want.score)
						report_mismatch("out_score", 48'(m_tdata[47:32]), 48'(want.score));
					if (m_tlast !== want.last)
						report_mismatch("last_out", 48'(m_tlast), 48'(want.last));
					if (m_tuser !== want.overflow)
						report_mismatch("overflow", 48'(m_tuser), 48'(want.overflow));
				end
			end
		end
	end

	// Sender: offers the next pending record once the previous transaction is done.
	always @(negedge clk) begin
		student_rec_t nxt;
		if (!s_tvalid || s_took) begin
			if (send_hold > 0) begin
				send_hold <= send_hold - 1;
				s_tvalid  <= 1'b0;
			end else if (pending_recs.size() != 0) begin
				nxt = pending_recs.pop_front();
				s_tvalid  <= 1'b1;
				s_tdata   <= {nxt.score, nxt.number};
				s_tlast   <= nxt.last;
				send_hold <= pick_gap(send_idle_en);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink: ready with random stalls between ready cycles.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready  <= 1'b1;
			sink_hold <= pick_gap(sink_idle_en);
		end
	end

	task automatic push_rec(logic [NUM_W-1:0] num, logic [SCORE_W-1:0] sc, logic last);
		student_rec_t r;
		r.number = num;
		r.score  = sc;
		r.last   = last;
		pending_recs.push_back(r);
		items_queued++;
	endtask

	// Equal numbers with different scores: order depends on whether score breaks the tie.
	task automatic push_tie_set();
		push_rec(32'd5, 16'd10, 1'b0);
		push_rec(32'hFFFF_FFFF, 16'd0, 1'b0);
		push_rec(32'd5, 16'd3, 1'b0);
		push_rec(32'd0, 16'hFFFF, 1'b0);
		push_rec(32'd5, 16'd10, 1'b1);
	endtask

	task automatic push_random_set(int n);
		for (int i = 0; i < n; i++)
			push_rec(rand_number(), rand_score(), i == n - 1);
	endtask

	function automatic int pick_set_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 95)
			return $urandom_range(7, 20);
		return $urandom_range(21, 40);
	endfunction

	// Holds off until every record is taken and every listing has come out.
	task automatic wait_drained();
		while (pending_recs.size() != 0 || s_tvalid || sorted_listing_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(mode_t m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		mode_t first_modes[4];
		int    full_sizes[3];
		int    full_idx;
		int    phase;
		first_modes = '{MODE_UNUSED, MODE_SCORE, MODE_NUM_SCORE, MODE_NUMBER};
		full_sizes  = '{64, 65, 66};
		full_idx    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, first under the reset mode (by score).
		push_rec(32'd0, 16'd0, 1'b1);
		push_rec(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		push_rec(32'd0, 16'hFFFF, 1'b0);
		push_rec(32'd7, 16'd0, 1'b0);
		push_rec(32'd3, 16'd100, 1'b0);
		push_rec(32'd9, 16'd100, 1'b0);
		push_rec(32'd2, 16'd0, 1'b0);
		push_rec(32'd1, 16'd100, 1'b1);
		wait_drained();
		write_mode(MODE_NUMBER);
		push_tie_set();
		wait_drained();
		write_mode(MODE_NUM_SCORE);
		push_tie_set();
		wait_drained();
		write_mode(MODE_UNUSED);
		push_tie_set();
		wait_drained();

		// Random part: each phase sets a mode and idle profile, then sends whole sets.
		// Every third phase, for the first three such phases, also sends one set that fills the store or overruns it.
		for (phase = 0; items_queued < RECORD_ITEMS; phase++) begin
			write_mode(phase < 4 ? first_modes[phase] : mode_t'($urandom_range(0, 3)));
			send_idle_en = ($urandom_range(0, 3) != 0);
			sink_idle_en = ($urandom_range(0, 3) != 0);
			if (phase % 3 == 1 && full_idx < 3) begin
				push_random_set(full_sizes[full_idx]);
				full_idx++;
			end
			repeat ($urandom_range(1, 4))
				push_random_set(pick_set_size());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
